// ===== rtl/core/zbtr_pkg.sv =====
`default_nettype none
package zbtr_pkg;

	localparam int KIND_W  = 2;
	localparam int COORD_W = 12;
	localparam int DEPTH_W = 16;
	localparam int PAINT_W = 24;
	localparam int COUNT_W = 13;
	localparam int CFG_W   = 7;
	localparam int POS_W   = 11;
	localparam int DIFF_W  = 13;
	localparam int PROD_W  = 26;
	localparam int STEP_W  = 14;
	localparam int EDGE_W  = 28;
	localparam int MUL_W   = DEPTH_W + EDGE_W - 1;
	localparam int ACC_W   = MUL_W + 2;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [DEPTH_W-1:0] DEPTH_MIN  = 16'h8000;
	localparam logic [CFG_W-1:0]   CFG_RESET  = 7'd64;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic                     skip;
		logic                     oor;
		logic [POS_W-1:0]         lox;
		logic [POS_W-1:0]         hix;
		logic [POS_W-1:0]         loy;
		logic [POS_W-1:0]         hiy;
		logic [EDGE_W-1:0]        den;
		logic signed [EDGE_W-1:0] n1;
		logic signed [EDGE_W-1:0] n2;
		logic signed [STEP_W-1:0] dn1x;
		logic signed [STEP_W-1:0] dn1y;
		logic signed [STEP_W-1:0] dn2x;
		logic signed [STEP_W-1:0] dn2y;
		logic [DEPTH_W-1:0]       e0;
		logic [DEPTH_W-1:0]       e1;
		logic [DEPTH_W-1:0]       e2;
		logic [PAINT_W-1:0]       paint;
	} job_t;

	typedef struct packed {
		logic [PAINT_W-1:0] colour;
		logic [DEPTH_W-1:0] depth;
		logic [COUNT_W-1:0] count;
		logic               oor;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/zbtr_intf.sv =====
`default_nettype none
interface zbtr_in_if;
	import zbtr_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [KIND_W-1:0]         kind;
	logic signed [COORD_W-1:0] x0;
	logic signed [COORD_W-1:0] y0;
	logic signed [COORD_W-1:0] x1;
	logic signed [COORD_W-1:0] y1;
	logic signed [COORD_W-1:0] x2;
	logic signed [COORD_W-1:0] y2;
	logic signed [DEPTH_W-1:0] depth0;
	logic signed [DEPTH_W-1:0] depth1;
	logic signed [DEPTH_W-1:0] depth2;
	logic [PAINT_W-1:0]        paint;
	modport source(output valid, kind, x0, y0, x1, y1, x2, y2, depth0, depth1, depth2, paint,
		input ready);
	modport sink(input valid, kind, x0, y0, x1, y1, x2, y2, depth0, depth1, depth2, paint,
		output ready);
endinterface

interface zbtr_out_if;
	import zbtr_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [PAINT_W-1:0]        pixel_colour;
	logic signed [DEPTH_W-1:0] pixel_depth;
	logic [COUNT_W-1:0]        written_count;
	logic                      out_of_range;
	modport source(output valid, pixel_colour, pixel_depth, written_count, out_of_range,
		input ready);
	modport sink(input valid, pixel_colour, pixel_depth, written_count, out_of_range,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/core/zbtr_ram.sv =====
`default_nettype none
module zbtr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/zbtr_front.sv =====
`default_nettype none
module zbtr_front (
	input  logic                      clk,
	input  logic                      arst_n,
	zbtr_in_if.sink                   in_ch,
	input  logic [zbtr_pkg::POS_W-1:0] eff_w,
	input  logic [zbtr_pkg::POS_W-1:0] eff_h,
	input  logic                      hold,
	output zbtr_pkg::job_t            job,
	output logic                      job_valid,
	input  logic                      job_ready
);
	import zbtr_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3;

	logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy, w13, h13;
	logic signed [DIFF_W-1:0] minx, maxx, miny, maxy, lox, hix, loy, hiy;
	logic                     empty, oor;

	logic [KIND_W-1:0]        kind_s1, kind_s2;
	logic signed [DIFF_W-1:0] dbx_s1, dby_s1, dcx_s1, dcy_s1, alx_s1, aly_s1;
	logic signed [DIFF_W-1:0] dbx_s2, dby_s2, dcx_s2, dcy_s2;
	logic [POS_W-1:0]         lox_s1, hix_s1, loy_s1, hiy_s1;
	logic [POS_W-1:0]         lox_s2, hix_s2, loy_s2, hiy_s2;
	logic                     empty_s1, empty_s2, oor_s1, oor_s2;
	logic [DEPTH_W-1:0]       e0_s1, e1_s1, e2_s1, e0_s2, e1_s2, e2_s2;
	logic [PAINT_W-1:0]       paint_s1, paint_s2;
	logic signed [PROD_W-1:0] pd0_s2, pd1_s2, pq0_s2, pq1_s2, pr0_s2, pr1_s2;

	logic signed [EDGE_W-1:0] den, n1, n2;
	logic                     neg;
	job_t                     job_s3;

	assign en          = !v_s3 || job_ready;
	assign in_ch.ready = en && !hold;
	assign job         = job_s3;
	assign job_valid   = v_s3;

	always_comb begin
		ax = DIFF_W'(in_ch.x0);
		ay = DIFF_W'(in_ch.y0);
		bx = DIFF_W'(in_ch.x1);
		by = DIFF_W'(in_ch.y1);
		cx = DIFF_W'(in_ch.x2);
		cy = DIFF_W'(in_ch.y2);
		w13 = DIFF_W'({2'b00, eff_w});
		h13 = DIFF_W'({2'b00, eff_h});
		minx = (ax < bx) ? ax : bx;
		minx = (minx < cx) ? minx : cx;
		maxx = (ax > bx) ? ax : bx;
		maxx = (maxx > cx) ? maxx : cx;
		miny = (ay < by) ? ay : by;
		miny = (miny < cy) ? miny : cy;
		maxy = (ay > by) ? ay : by;
		maxy = (maxy > cy) ? maxy : cy;
		lox = (minx < 0) ? '0 : minx;
		loy = (miny < 0) ? '0 : miny;
		hix = (maxx > w13 - 1) ? w13 - 1 : maxx;
		hiy = (maxy > h13 - 1) ? h13 - 1 : maxy;
		empty = (lox > hix) || (loy > hiy);
		oor = (ax < 0) || (ay < 0) || (ax >= w13) || (ay >= h13);
	end

	always_comb begin
		den = EDGE_W'(pd0_s2) - EDGE_W'(pd1_s2);
		n1  = EDGE_W'(pq0_s2) - EDGE_W'(pq1_s2);
		n2  = EDGE_W'(pr0_s2) - EDGE_W'(pr1_s2);
		neg = den[EDGE_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid && in_ch.ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= in_ch.kind;
			dbx_s1   <= bx - ax;
			dby_s1   <= by - ay;
			dcx_s1   <= cx - ax;
			dcy_s1   <= cy - ay;
			alx_s1   <= ax - lox;
			aly_s1   <= ay - loy;
			empty_s1 <= empty;
			oor_s1   <= oor;
			e0_s1    <= in_ch.depth0 ^ DEPTH_MIN;
			e1_s1    <= in_ch.depth1 ^ DEPTH_MIN;
			e2_s1    <= in_ch.depth2 ^ DEPTH_MIN;
			paint_s1 <= in_ch.paint;
			if (in_ch.kind == KIND_READ) begin
				lox_s1 <= POS_W'(in_ch.x0);
				loy_s1 <= POS_W'(in_ch.y0);
			end else begin
				lox_s1 <= POS_W'(lox);
				loy_s1 <= POS_W'(loy);
			end
			hix_s1 <= POS_W'(hix);
			hiy_s1 <= POS_W'(hiy);

			kind_s2  <= kind_s1;
			dbx_s2   <= dbx_s1;
			dby_s2   <= dby_s1;
			dcx_s2   <= dcx_s1;
			dcy_s2   <= dcy_s1;
			lox_s2   <= lox_s1;
			hix_s2   <= hix_s1;
			loy_s2   <= loy_s1;
			hiy_s2   <= hiy_s1;
			empty_s2 <= empty_s1;
			oor_s2   <= oor_s1;
			e0_s2    <= e0_s1;
			e1_s2    <= e1_s1;
			e2_s2    <= e2_s1;
			paint_s2 <= paint_s1;
			pd0_s2   <= dcx_s1 * dby_s1;
			pd1_s2   <= dbx_s1 * dcy_s1;
			pq0_s2   <= alx_s1 * dcy_s1;
			pq1_s2   <= dcx_s1 * aly_s1;
			pr0_s2   <= dbx_s1 * aly_s1;
			pr1_s2   <= alx_s1 * dby_s1;

			job_s3.kind  <= kind_s2;
			job_s3.skip  <= empty_s2 || (den == '0);
			job_s3.oor   <= oor_s2;
			job_s3.lox   <= lox_s2;
			job_s3.hix   <= hix_s2;
			job_s3.loy   <= loy_s2;
			job_s3.hiy   <= hiy_s2;
			job_s3.den   <= neg ? -den : den;
			job_s3.n1    <= neg ? -n1 : n1;
			job_s3.n2    <= neg ? -n2 : n2;
			job_s3.dn1y  <= neg ? -STEP_W'(dcx_s2) : STEP_W'(dcx_s2);
			job_s3.dn2y  <= neg ? STEP_W'(dbx_s2) : -STEP_W'(dbx_s2);
			job_s3.dn1x  <= neg ? STEP_W'(dcy_s2) : -STEP_W'(dcy_s2);
			job_s3.dn2x  <= neg ? -STEP_W'(dby_s2) : STEP_W'(dby_s2);
			job_s3.e0    <= e0_s2;
			job_s3.e1    <= e1_s2;
			job_s3.e2    <= e2_s2;
			job_s3.paint <= paint_s2;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/zbtr_queue.sv =====
`default_nettype none
module zbtr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  zbtr_pkg::job_t push_data,
	input  logic           push_valid,
	output logic           push_ready,
	output zbtr_pkg::job_t pop_data,
	output logic           pop_valid,
	input  logic           pop_ready
);
	import zbtr_pkg::*;

	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       do_push, do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = slot_q[rp_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/zbtr_back.sv =====
`default_nettype none
module zbtr_back #(
	parameter int MAX_WIDTH  = zbtr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = zbtr_pkg::DEF_MAX_HEIGHT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  zbtr_pkg::job_t job,
	input  logic           job_valid,
	output logic           job_ready,
	output logic           init_busy,
	zbtr_out_if.source     out_ch
);
	import zbtr_pkg::*;

	localparam int SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW   = (SIZE > 1) ? $clog2(SIZE) : 1;

	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_PIX   = 4'd2;
	localparam logic [3:0] ST_MUL   = 4'd3;
	localparam logic [3:0] ST_DIV   = 4'd4;
	localparam logic [3:0] ST_TEST  = 4'd5;
	localparam logic [3:0] ST_CLEAR = 4'd6;
	localparam logic [3:0] ST_READ  = 4'd7;
	localparam logic [3:0] ST_RDATA = 4'd8;

	logic [3:0]               state_q;
	job_t                     cur_q;
	logic [POS_W-1:0]         px_q, py_q;
	logic signed [EDGE_W-1:0] n0_q, n1_q, n2_q, n1c_q, n2c_q;
	logic [ACC_W-1:0]         acc_q;
	logic [1:0]               mstep_q;
	logic [3:0]               dstep_q;
	logic [EDGE_W-1:0]        rem_q;
	logic [DEPTH_W-1:0]       low_q;
	logic [COUNT_W-1:0]       count_q;
	logic [AW-1:0]            sweep_q, raddr_q;
	result_t                  res_q;
	logic                     res_v_q;

	logic                     take, res_set;
	logic signed [EDGE_W-1:0] n0, n1c_x, n2c_x;
	logic                     covered, last_y, last_x, pass;
	logic [AW-1:0]            addr;
	logic [DEPTH_W-1:0]       mul_e;
	logic [EDGE_W-2:0]        mul_n;
	logic [MUL_W-1:0]         prod;
	logic [ACC_W-1:0]         sum;
	logic [EDGE_W:0]          trial;
	logic                     qbit;
	logic signed [DEPTH_W-1:0] z, stored;

	logic               d_we, c_we;
	logic [AW-1:0]      wa;
	logic [DEPTH_W-1:0] d_wd, d_rd;
	logic [PAINT_W-1:0] c_wd, c_rd;

	assign take      = job_valid && (!res_v_q || out_ch.ready) && (state_q == ST_IDLE);
	assign job_ready = take;
	assign init_busy = (state_q == ST_INIT);

	assign out_ch.valid         = res_v_q;
	assign out_ch.pixel_colour  = res_q.colour;
	assign out_ch.pixel_depth   = res_q.depth;
	assign out_ch.written_count = res_q.count;
	assign out_ch.out_of_range  = res_q.oor;

	always_comb begin
		n0      = $signed(cur_q.den) - n1_q - n2_q;
		covered = !n0[EDGE_W-1] && !n1_q[EDGE_W-1] && !n2_q[EDGE_W-1];
		addr    = AW'(32'(py_q) * MAX_WIDTH + 32'(px_q));
		last_y  = (py_q == cur_q.hiy);
		last_x  = (px_q == cur_q.hix);
		n1c_x   = n1c_q + EDGE_W'(cur_q.dn1x);
		n2c_x   = n2c_q + EDGE_W'(cur_q.dn2x);
		case (mstep_q)
			2'd0: begin
				mul_e = cur_q.e0;
				mul_n = n0_q[EDGE_W-2:0];
			end
			2'd1: begin
				mul_e = cur_q.e1;
				mul_n = n1_q[EDGE_W-2:0];
			end
			default: begin
				mul_e = cur_q.e2;
				mul_n = n2_q[EDGE_W-2:0];
			end
		endcase
		prod   = mul_e * mul_n;
		sum    = acc_q + ACC_W'(prod);
		trial  = {rem_q, low_q[DEPTH_W-1]};
		qbit   = (trial >= (EDGE_W+1)'(cur_q.den));
		z      = $signed({~low_q[DEPTH_W-1], low_q[DEPTH_W-2:0]});
		stored = $signed(d_rd);
		pass   = (state_q == ST_TEST) && (z > stored);
		res_set = (take && !(job.kind == KIND_DRAW && !job.skip) && (job.kind != KIND_CLEAR)
			&& !(job.kind == KIND_READ && !job.oor))
			|| (((state_q == ST_PIX && !covered) || state_q == ST_TEST) && last_y && last_x)
			|| (state_q == ST_CLEAR && sweep_q == AW'(SIZE - 1))
			|| (state_q == ST_RDATA);
	end

	always_comb begin
		d_we = 1'b0;
		c_we = 1'b0;
		wa   = raddr_q;
		d_wd = DEPTH_MIN;
		c_wd = '0;
		case (state_q)
			ST_INIT: begin
				d_we = 1'b1;
				c_we = 1'b1;
				wa   = sweep_q;
			end
			ST_CLEAR: begin
				d_we = 1'b1;
				wa   = sweep_q;
			end
			ST_TEST: begin
				d_we = pass;
				c_we = pass;
				d_wd = z;
				c_wd = cur_q.paint;
			end
			default: begin
				d_we = 1'b0;
			end
		endcase
	end

	zbtr_ram #(.WIDTH(DEPTH_W), .DEPTH(SIZE)) u_depth (
		.clk(clk), .we(d_we), .waddr(wa), .wdata(d_wd), .raddr(raddr_q), .rdata(d_rd)
	);

	zbtr_ram #(.WIDTH(PAINT_W), .DEPTH(SIZE)) u_colour (
		.clk(clk), .we(c_we), .waddr(wa), .wdata(c_wd), .raddr(raddr_q), .rdata(c_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			sweep_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (res_set) begin
				res_v_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						sweep_q <= '0;
						if (job.kind == KIND_DRAW && !job.skip) begin
							state_q <= ST_PIX;
						end else if (job.kind == KIND_CLEAR) begin
							state_q <= ST_CLEAR;
						end else if (job.kind == KIND_READ && !job.oor) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_PIX: begin
					if (covered) begin
						state_q <= ST_MUL;
					end else if (last_y && last_x) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					if (mstep_q == 2'd2) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dstep_q == 4'd15) begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (last_y && last_x) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PIX;
					end
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					state_q <= ST_RDATA;
				end
				ST_RDATA: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					cur_q        <= job;
					px_q         <= job.lox;
					py_q         <= job.loy;
					n1_q         <= job.n1;
					n2_q         <= job.n2;
					n1c_q        <= job.n1;
					n2c_q        <= job.n2;
					count_q      <= '0;
					raddr_q      <= AW'(32'(job.loy) * MAX_WIDTH + 32'(job.lox));
					res_q.colour <= '0;
					res_q.depth  <= '0;
					res_q.count  <= '0;
					res_q.oor    <= (job.kind == KIND_READ) && job.oor;
				end
			end
			ST_PIX: begin
				n0_q    <= n0;
				raddr_q <= addr;
				acc_q   <= '0;
				mstep_q <= 2'd0;
			end
			ST_MUL: begin
				acc_q   <= sum;
				mstep_q <= mstep_q + 2'd1;
				rem_q   <= EDGE_W'(sum[ACC_W-1:DEPTH_W]);
				low_q   <= sum[DEPTH_W-1:0];
				dstep_q <= 4'd0;
			end
			ST_DIV: begin
				rem_q   <= qbit ? EDGE_W'(trial - (EDGE_W+1)'(cur_q.den)) : EDGE_W'(trial);
				low_q   <= {low_q[DEPTH_W-2:0], qbit};
				dstep_q <= dstep_q + 4'd1;
			end
			ST_RDATA: begin
				res_q.colour <= c_rd;
				res_q.depth  <= d_rd;
			end
			default: begin
			end
		endcase
		if ((state_q == ST_PIX && !covered) || state_q == ST_TEST) begin
			if (!last_y) begin
				py_q <= py_q + 1'b1;
				n1_q <= n1_q + EDGE_W'(cur_q.dn1y);
				n2_q <= n2_q + EDGE_W'(cur_q.dn2y);
			end else if (!last_x) begin
				px_q  <= px_q + 1'b1;
				py_q  <= cur_q.loy;
				n1c_q <= n1c_x;
				n2c_q <= n2c_x;
				n1_q  <= n1c_x;
				n2_q  <= n2c_x;
			end
			if (pass) begin
				count_q     <= count_q + 1'b1;
				res_q.count <= count_q + 1'b1;
			end else begin
				res_q.count <= count_q;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/zbuffer_triangle_rasterizer_unit.sv =====
// channel  role    handshake       payload
// in_ch    sink    valid / ready   kind, x0..y2, depth0..depth2, paint
// out_ch   source  valid / ready   pixel_colour, pixel_depth, written_count, out_of_range
// cfg      write   cfg_we          cfg_index, cfg_data
// a draw visits each pixel of the clipped box, and each covered pixel then takes
// 3 multiply-accumulate steps, 16 divide steps and a depth test
// a clear sweeps all MAX_WIDTH*MAX_HEIGHT depth entries, a read uses the store's registered port
// after reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries runs before beats are taken
// a 3-stage front end and 2-entry queue keep taking beats while the back end is busy, until both are full
`default_nettype none
module zbuffer_triangle_rasterizer_unit #(
	parameter int MAX_WIDTH  = zbtr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = zbtr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	zbtr_in_if.sink                   in_ch,
	zbtr_out_if.source                out_ch,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [zbtr_pkg::CFG_W-1:0] cfg_data
);
	import zbtr_pkg::*;

	localparam logic REG_SCREEN_WIDTH  = 1'b0;
	localparam logic REG_SCREEN_HEIGHT = 1'b1;

	logic [CFG_W-1:0] width_q, height_q;
	logic [POS_W-1:0] eff_w, eff_h;
	job_t             f_job, q_job;
	logic             f_valid, f_ready, q_valid, q_ready, init_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q <= cfg_data;
				REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default:           width_q <= width_q;
			endcase
		end
	end

	assign eff_w = (32'(width_q) > MAX_WIDTH) ? POS_W'(MAX_WIDTH) : POS_W'(width_q);
	assign eff_h = (32'(height_q) > MAX_HEIGHT) ? POS_W'(MAX_HEIGHT) : POS_W'(height_q);

	zbtr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .eff_w(eff_w), .eff_h(eff_h),
		.hold(init_busy), .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
	);

	zbtr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_data(f_job), .push_valid(f_valid),
		.push_ready(f_ready), .pop_data(q_job), .pop_valid(q_valid), .pop_ready(q_ready)
	);

	zbtr_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n), .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
		.init_busy(init_busy), .out_ch(out_ch)
	);
endmodule
`default_nettype wire
